[hdl/arprm_pkg.sv]
package arprm_pkg;

  localparam int unsigned DefaultEntries = 256;
  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] ArpOpReply = 16'h0002;
  localparam logic [7:0] RepeatMax = 8'd255;
  localparam logic [31:0] MaxAgeReset = 32'd300;
  localparam logic [15:0] MinGapReset = 16'd1;
  localparam logic [7:0] ThresholdReset = 8'd1;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam logic [CfgIndexWidth-1:0] RegMaxAge = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegMinGap = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegThreshold = 2'd2;

  typedef enum logic [2:0] {
    StatusNotArp = 3'd0,
    StatusNotReply = 3'd1,
    StatusKnown = 3'd2,
    StatusAdded = 3'd3,
    StatusFull = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [15:0] arp_operation;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic replay_alarm;
    logic [7:0] repeat_count;
    logic ip_changed;
    logic [8:0] occupancy;
  } out_word_t;

  // Classified job passed from the front to the back.
  typedef struct packed {
    logic is_reply;
    logic [2:0] status;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] now;
  } job_t;

endpackage

[hdl/arprm_if.sv]
interface arprm_in_if;
  import arprm_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface arprm_out_if;
  import arprm_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hdl/arp_reply_replay_monitor_unit.sv]
// ARP reply replay monitor.
// Input channel in_ch carries one parsed frame per word; output channel
// out_ch returns exactly one result word per input word, in order.
// Both channels use valid/ready; a word moves when both are high.
// Configuration is a write port (cfg_we, cfg_index, cfg_data) that must be
// used only while the block is idle.
// The front stage classifies each frame and holds it in a one-word queue,
// so a new word is taken while the back part is still busy.
// The back part sweeps the whole table once per word through one read
// port of the entry memory, aging entries and looking up the MAC together.
// A reply passes through Scan, Decide, Fetch, Finish and Emit, other frames
// skip Fetch and Finish; the Scan length is set by that single-port sweep;
// one item is worked on at a time.
// The result is held in an output register until the receiver takes it;
// while the receiver stalls, the back part waits and the front queue fills.
// Synchronous reset clears the valid bits, count, state and out_ch.valid, sets
// the config registers to defaults; no clearing pass over the memory is needed.
module arp_reply_replay_monitor_unit #(
  parameter int unsigned TABLE_ENTRIES = arprm_pkg::DefaultEntries
) (
  input logic clk,
  input logic rst,
  arprm_in_if.sink in_ch,
  arprm_out_if.source out_ch,
  input logic cfg_we,
  input logic [arprm_pkg::CfgIndexWidth-1:0] cfg_index,
  input logic [arprm_pkg::CfgDataWidth-1:0] cfg_data
);
  import arprm_pkg::*;

  logic [31:0] max_age;
  logic [15:0] min_gap;
  logic [7:0] threshold;
  job_t job;
  logic job_valid;
  logic job_ready;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= MaxAgeReset;
      min_gap <= MinGapReset;
      threshold <= ThresholdReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMaxAge: max_age <= cfg_data;
        RegMinGap: min_gap <= cfg_data[15:0];
        RegThreshold: threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  arprm_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .job(job), .job_valid(job_valid), .job_ready(job_ready)
  );

  arprm_back #(.TableEntries(TABLE_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .job(job), .job_valid(job_valid),
    .job_ready(job_ready), .max_age(max_age), .min_gap(min_gap),
    .threshold(threshold), .out_ch(out_ch)
  );
endmodule

[hdl/arprm_ram.sv]
module arprm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input logic clk,
  input logic we,
  input logic [$clog2(Depth)-1:0] waddr,
  input logic [Width-1:0] wdata,
  input logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/arprm_front.sv]
module arprm_front (
  input logic clk,
  input logic rst,
  arprm_in_if.sink in_ch,
  output arprm_pkg::job_t job,
  output logic job_valid,
  input logic job_ready
);
  import arprm_pkg::*;

  job_t job_next;

  // Single-entry queue between front and back.
  assign in_ch.ready = !job_valid || job_ready;

  always_comb begin
    job_next.mac = in_ch.data.src_mac;
    job_next.ip = in_ch.data.src_ip;
    job_next.now = in_ch.data.now_seconds;
    job_next.is_reply = 1'b0;
    if (in_ch.data.eth_type != EtherTypeArp) begin
      job_next.status = StatusNotArp;
    end else if (in_ch.data.arp_operation != ArpOpReply) begin
      job_next.status = StatusNotReply;
    end else begin
      job_next.status = StatusKnown;
      job_next.is_reply = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      job <= job_next;
    end
  end
endmodule

[hdl/arprm_back.sv]
module arprm_back #(
  parameter int unsigned TableEntries = arprm_pkg::DefaultEntries
) (
  input logic clk,
  input logic rst,
  input arprm_pkg::job_t job,
  input logic job_valid,
  output logic job_ready,
  input logic [31:0] max_age,
  input logic [15:0] min_gap,
  input logic [7:0] threshold,
  arprm_out_if.source out_ch
);
  import arprm_pkg::*;

  localparam int unsigned Aw = $clog2(TableEntries);
  localparam int unsigned Cw = $clog2(TableEntries + 1);
  localparam int unsigned RamW = 48 + 32 + 32 + 8;
  localparam logic [Aw-1:0] LastIdx = Aw'(TableEntries - 1);

  typedef enum logic [2:0] {
    Idle, Scan, Decide, Fetch, Finish, Emit
  } state_t;

  state_t state;
  job_t cur;
  logic [TableEntries-1:0] valid_bits;
  logic [Cw-1:0] valid_count;
  logic [Aw-1:0] raddr;
  logic [Aw-1:0] chk_idx;
  logic chk_live;
  logic scan_last;
  logic hit_found;
  logic [Aw-1:0] hit_idx;
  logic free_found;
  logic [Aw-1:0] free_idx;
  logic we;
  logic [Aw-1:0] waddr;
  logic [RamW-1:0] wdata;
  logic [RamW-1:0] rdata;
  logic [47:0] r_mac;
  logic [31:0] r_ip;
  logic [31:0] r_time;
  logic [7:0] r_rep;
  logic [31:0] idle_t;
  logic [7:0] rep_inc;

  assign {r_mac, r_ip, r_time, r_rep} = rdata;
  assign idle_t = cur.now - r_time;
  assign rep_inc = (r_rep < RepeatMax) ? r_rep + 8'd1 : r_rep;
  assign job_ready = (state == Idle);

  arprm_ram #(.Width(RamW), .Depth(TableEntries)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    we = 1'b0;
    waddr = hit_idx;
    wdata = {r_mac, cur.ip, cur.now, 8'd0};
    if (state == Finish) begin
      if (hit_found) begin
        we = 1'b1;
        wdata = {r_mac, cur.ip, cur.now,
                 (idle_t < {16'd0, min_gap}) ? rep_inc : 8'd0};
      end else if (free_found) begin
        we = 1'b1;
        waddr = free_idx;
        wdata = {cur.mac, cur.ip, cur.now, 8'd0};
      end
    end
  end

  // Scan reads one entry a cycle; the data arrives in the cycle after raddr.
  // The check of the last entry sees scan_last set, so chk_live drops there.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      valid_bits <= '0;
      valid_count <= '0;
      out_ch.valid <= 1'b0;
      chk_live <= 1'b0;
    end else begin
      unique case (state)
        Idle: begin
          if (job_valid) begin
            cur <= job;
            raddr <= '0;
            chk_live <= 1'b0;
            scan_last <= 1'b0;
            hit_found <= 1'b0;
            free_found <= 1'b0;
            state <= Scan;
          end
        end
        Scan: begin
          chk_live <= !scan_last;
          chk_idx <= raddr;
          if (raddr != LastIdx) begin
            raddr <= raddr + 1'b1;
          end else begin
            scan_last <= 1'b1;
          end
          if (chk_live) begin
            if (valid_bits[chk_idx] && idle_t > max_age) begin
              valid_bits[chk_idx] <= 1'b0;
              valid_count <= valid_count - 1'b1;
              if (!free_found) begin
                free_found <= 1'b1;
                free_idx <= chk_idx;
              end
            end else if (valid_bits[chk_idx]) begin
              if (!hit_found && r_mac == cur.mac) begin
                hit_found <= 1'b1;
                hit_idx <= chk_idx;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx <= chk_idx;
            end
            if (chk_idx == LastIdx) begin
              state <= Decide;
            end
          end
        end
        Decide: begin
          raddr <= hit_idx;
          state <= cur.is_reply ? Fetch : Emit;
          out_ch.data.status <= cur.status;
          out_ch.data.replay_alarm <= 1'b0;
          out_ch.data.repeat_count <= '0;
          out_ch.data.ip_changed <= 1'b0;
        end
        Fetch: state <= Finish;
        Finish: begin
          if (hit_found) begin
            out_ch.data.status <= StatusKnown;
            out_ch.data.ip_changed <= (r_ip != cur.ip);
            if (idle_t < {16'd0, min_gap}) begin
              out_ch.data.repeat_count <= rep_inc;
              out_ch.data.replay_alarm <= (rep_inc > threshold);
            end
          end else if (free_found) begin
            out_ch.data.status <= StatusAdded;
            valid_bits[free_idx] <= 1'b1;
            valid_count <= valid_count + 1'b1;
          end else begin
            out_ch.data.status <= StatusFull;
          end
          state <= Emit;
        end
        Emit: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.data.occupancy <= 9'(valid_count);
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= Idle;
          end
        end
        default: state <= Idle;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == Emit)
    else $error("result shown outside emit");
  assert property (@(posedge clk) disable iff (rst)
    (state == Finish && !hit_found && free_found) |=> valid_bits[$past(free_idx)])
    else $error("new entry not marked valid");
  assert property (@(posedge clk) disable iff (rst)
    valid_count <= Cw'(TableEntries))
    else $error("occupancy overflow");
endmodule
